[src/circular_queue_fifo_defines.svh]
// ----------------------------------------------------------------------------
// circular_queue_fifo assertion macros
// Shared concurrent assertion forms for the queue RTL.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_FIFO_DEFINES_SVH
`define CIRCULAR_QUEUE_FIFO_DEFINES_SVH

// same-cycle implication
`define CQF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cqf assertion failed");

// next-cycle implication
`define CQF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cqf assertion failed");

`endif

[src/cqf_pkg.sv]
// ----------------------------------------------------------------------------
// cqf_pkg
// Types and constants shared by the circular queue controller and datapath.
// ----------------------------------------------------------------------------
package cqf_pkg;

  localparam int unsigned DEPTH_DEF     = 64;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned CAP_W         = 7;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned VAL_W         = 32;

  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DISPLAY = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic    push;       // write push value at tail
    logic    pop;        // read head, advance head
    logic    walk_init;  // walk pointer to head
    logic    walk_rd;    // read at walk pointer
    logic    walk_next;  // advance walk pointer
    logic    out_load;
    logic    out_mem;    // result data from read register
    logic    out_last;
    status_e out_status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic walk_end;
    logic out_free;
  } sts_t;

endpackage

[src/cqf_ctrl.sv]
// ----------------------------------------------------------------------------
// cqf_ctrl
// Sequencer: decodes opcodes, drives datapath commands, walks display.
// ----------------------------------------------------------------------------
module cqf_ctrl import cqf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [OP_W-1:0] opcode_i,
  input  sts_t            sts_i,
  output cmd_t            cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_REM  = 4'b0010,
    S_DRD  = 4'b0100,
    S_DLD  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          unique case (opcode_i)
            OP_INSERT: begin
              cmd_o.push       = !sts_i.full;
              cmd_o.out_load   = 1'b1;
              cmd_o.out_last   = 1'b1;
              cmd_o.out_status = sts_i.full ? ST_FULL : ST_OK;
            end
            OP_REMOVE: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
              end else begin
                cmd_o.pop = 1'b1;
                state_d   = S_REM;
              end
            end
            OP_DISPLAY: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
              end else begin
                cmd_o.walk_init = 1'b1;
                state_d         = S_DRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_REM: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_mem    = 1'b1;
          cmd_o.out_last   = 1'b1;
          cmd_o.out_status = ST_OK;
          state_d          = S_IDLE;
        end
      end
      S_DRD: begin
        cmd_o.walk_rd = 1'b1;
        state_d       = S_DLD;
      end
      S_DLD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_mem    = 1'b1;
          cmd_o.out_last   = sts_i.walk_end;
          cmd_o.out_status = ST_OK;
          if (sts_i.walk_end) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.walk_next = 1'b1;
            state_d         = S_DRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/cqf_dp.sv]
// ----------------------------------------------------------------------------
// cqf_dp
// Ring storage, head/tail/occupancy, walk pointer and output register.
// ----------------------------------------------------------------------------
module cqf_dp import cqf_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CAP_W-1:0]        cfg_wdata_i,
  input  logic signed [VAL_W-1:0] push_value_i,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              out_status_o,
  output logic signed [VAL_W-1:0] out_value_o,
  output logic                    out_last_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] ring_q, ring_d;
  logic [IDX_W-1:0] head_q, tail_q, walk_q;
  logic [CNT_W-1:0] occ_q, cnt_q;
  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;

  logic                    out_valid_q;
  logic [1:0]              out_status_q;
  logic signed [VAL_W-1:0] out_value_q;
  logic                    out_last_q;

  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
                                           input logic [CNT_W-1:0] ring);
    logic [CNT_W-1:0] n;
    n = CNT_W'(idx) + 1'b1;
    return (n >= ring) ? '0 : IDX_W'(n);
  endfunction

  always_comb begin
    if (cfg_wdata_i == '0) begin
      ring_d = CNT_W'(1);
    end else if (cfg_wdata_i > CAP_W'(DEPTH)) begin
      ring_d = CNT_W'(DEPTH);
    end else begin
      ring_d = CNT_W'(cfg_wdata_i);
    end
  end

  assign sts_o.full     = (occ_q >= ring_q);
  assign sts_o.empty    = (occ_q == '0);
  assign sts_o.walk_end = (CNT_W'(cnt_q + 1'b1) == occ_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= CNT_W'(DEPTH);
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
      walk_q <= '0;
      cnt_q  <= '0;
    end else if (cfg_we_i) begin
      ring_q <= ring_d;
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
    end else begin
      if (cmd_i.push) begin
        tail_q <= adv(tail_q, ring_q);
        occ_q  <= occ_q + 1'b1;
      end
      if (cmd_i.pop) begin
        head_q <= adv(head_q, ring_q);
        occ_q  <= occ_q - 1'b1;
      end
      if (cmd_i.walk_init) begin
        walk_q <= head_q;
        cnt_q  <= '0;
      end else if (cmd_i.walk_next) begin
        walk_q <= adv(walk_q, ring_q);
        cnt_q  <= cnt_q + 1'b1;
      end
    end
  end

  assign rd_en   = cmd_i.pop || cmd_i.walk_rd;
  assign rd_addr = cmd_i.pop ? head_q : walk_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[tail_q] <= WORD_BITS'(push_value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_last_q   <= cmd_i.out_last;
      out_value_q  <= cmd_i.out_mem ? VAL_W'($signed(rdata_q)) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_last_o   = out_last_q;

endmodule

[src/circular_queue_fifo.sv]
// Latency: insert, full and empty results are valid the cycle after acceptance;
// a remove result passes through the storage read register, then the output register.
// Display emits one entry at a time (read, then load the output register).
// Throughput: one item at a time; the next item is taken once the last result loads and the output is free.
// Reset: head, tail and occupancy clear, capacity returns to the full depth;
// the storage array is not cleared. A capacity write also empties the queue.
// ----------------------------------------------------------------------------
// circular_queue_fifo
// Ring-buffer queue with settable capacity: insert, remove, display.
// ----------------------------------------------------------------------------
`include "circular_queue_fifo_defines.svh"

module circular_queue_fifo import cqf_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CAP_W-1:0]        cfg_wdata_i,     // capacity
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic signed [VAL_W-1:0] s_axis_tdata,    // push_value
  input  logic [OP_W-1:0]         s_axis_tuser,    // opcode
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic signed [VAL_W-1:0] m_axis_tdata,    // entry_value
  output logic [1:0]              m_axis_tuser,    // status
  output logic                    m_axis_tlast
);

  cmd_t cmd;
  sts_t sts;
  logic in_accept;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  cqf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .opcode_i   (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cqf_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_value_i (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_value_o  (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  `CQF_ASSERT_NOW(a_pop_not_empty, cmd.pop, !sts.empty)
  `CQF_ASSERT_NXT(a_remove_empty, in_accept && s_axis_tuser == OP_REMOVE && sts.empty && !cfg_we_i, m_axis_tvalid && m_axis_tuser == ST_EMPTY && m_axis_tlast)
  `CQF_ASSERT_NXT(a_insert_ok, in_accept && s_axis_tuser == OP_INSERT && !sts.full && !cfg_we_i, m_axis_tvalid && m_axis_tuser == ST_OK && m_axis_tlast && m_axis_tdata == '0)

endmodule
